@@ hdl/brc_pkg.sv @@
package brc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned EdgeW  = 18;
  localparam int unsigned PixW   = 30;
  localparam int unsigned AddrW  = 5;

  // largest coordinate, at edge width for the saturating compare
  localparam logic signed [EdgeW-1:0] CoordMax = 18'sd32767;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] RegSurfaceWidth  = 3'd0;
  localparam logic [2:0] RegSurfaceHeight = 3'd1;
  localparam logic [2:0] RegClipLeft      = 3'd2;
  localparam logic [2:0] RegClipTop       = 3'd3;
  localparam logic [2:0] RegClipWidth     = 3'd4;
  localparam logic [2:0] RegClipHeight    = 3'd5;

  localparam logic [SizeW-1:0] SurfaceWidthRst  = 15'd320;
  localparam logic [SizeW-1:0] SurfaceHeightRst = 15'd240;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic        [SizeW-1:0]  w;
    logic        [SizeW-1:0]  h;
  } box_t;

  typedef struct packed {
    logic signed [CoordW-1:0] area_x;
    logic signed [CoordW-1:0] area_y;
    logic        [SizeW-1:0]  area_w;
    logic        [SizeW-1:0]  area_h;
    logic                     part_given;
    logic signed [CoordW-1:0] part_x;
    logic signed [CoordW-1:0] part_y;
    logic        [SizeW-1:0]  part_w;
    logic        [SizeW-1:0]  part_h;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] from_x;
    logic signed [CoordW-1:0] from_y;
    logic        [SizeW-1:0]  from_w;
    logic        [SizeW-1:0]  from_h;
    logic signed [CoordW-1:0] to_x;
    logic signed [CoordW-1:0] to_y;
    logic        [SizeW-1:0]  to_w;
    logic        [SizeW-1:0]  to_h;
    logic        [PixW-1:0]   pixel_total;
  } out_word_t;

  // overlap of two boxes; empty overlap gives all zeros
  function automatic box_t box_and(box_t a, box_t b);
    logic signed [EdgeW-1:0] a_xe;
    logic signed [EdgeW-1:0] b_xe;
    logic signed [EdgeW-1:0] a_ye;
    logic signed [EdgeW-1:0] b_ye;
    logic signed [EdgeW-1:0] x_hi;
    logic signed [EdgeW-1:0] y_hi;
    logic signed [EdgeW-1:0] w_d;
    logic signed [EdgeW-1:0] h_d;
    logic signed [CoordW-1:0] x_lo;
    logic signed [CoordW-1:0] y_lo;
    box_t r;
    a_xe = EdgeW'(a.x) + $signed({3'b000, a.w});
    b_xe = EdgeW'(b.x) + $signed({3'b000, b.w});
    a_ye = EdgeW'(a.y) + $signed({3'b000, a.h});
    b_ye = EdgeW'(b.y) + $signed({3'b000, b.h});
    x_lo = (a.x > b.x) ? a.x : b.x;
    y_lo = (a.y > b.y) ? a.y : b.y;
    x_hi = (a_xe < b_xe) ? a_xe : b_xe;
    y_hi = (a_ye < b_ye) ? a_ye : b_ye;
    w_d  = x_hi - EdgeW'(x_lo);
    h_d  = y_hi - EdgeW'(y_lo);
    r = '0;
    if (a.w != '0 && a.h != '0 && b.w != '0 && b.h != '0 &&
        w_d > 18'sd0 && h_d > 18'sd0) begin
      r.x = x_lo;
      r.y = y_lo;
      r.w = w_d[SizeW-1:0];
      r.h = h_d[SizeW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/bitblt_rectangle_clipper_core.sv @@
// channel | direction | handshake            | word
// in      | sink      | in_valid_i/in_stall_o | in_word_t: source area, part, target origin
// out     | source    | out_valid_o/out_stall_i | out_word_t: clipped rectangles, pixel count
// cfg     | sink      | APB psel/penable      | surface size and global clip
//
// Four register stages: clip and source overlap, destination overlap, left/top
// shift, pixel product. One word per cycle while the output is not stalled.
// Reset empties every stage and loads the surface size 320 x 240, no clip.
// A stall only holds the stages that are full; empty stages keep filling.
module bitblt_rectangle_clipper_core
  import brc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SizeW-1:0]         surface_width_q, surface_height_q;
  logic signed [CoordW-1:0] clip_left_q, clip_top_q;
  logic [SizeW-1:0]         clip_width_q, clip_height_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surface_width_q  <= SurfaceWidthRst;
      surface_height_q <= SurfaceHeightRst;
      clip_left_q      <= '0;
      clip_top_q       <= '0;
      clip_width_q     <= '0;
      clip_height_q    <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegSurfaceWidth:  surface_width_q  <= pwdata[SizeW-1:0];
        RegSurfaceHeight: surface_height_q <= pwdata[SizeW-1:0];
        RegClipLeft:      clip_left_q      <= pwdata[CoordW-1:0];
        RegClipTop:       clip_top_q       <= pwdata[CoordW-1:0];
        RegClipWidth:     clip_width_q     <= pwdata[SizeW-1:0];
        RegClipHeight:    clip_height_q    <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegSurfaceWidth:  prdata = {17'd0, surface_width_q};
      RegSurfaceHeight: prdata = {17'd0, surface_height_q};
      RegClipLeft:      prdata = {16'd0, clip_left_q};
      RegClipTop:       prdata = {16'd0, clip_top_q};
      RegClipWidth:     prdata = {17'd0, clip_width_q};
      RegClipHeight:    prdata = {17'd0, clip_height_q};
      default:          prdata = '0;
    endcase
  end

  // stage flow: a stage loads when it is empty or its successor moves on
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !out_valid_q || !out_stall_i;
  assign rdy3       = !s3_valid_q || rdy4;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q  <= in_valid_i;
      if (rdy2) s2_valid_q  <= s1_valid_q;
      if (rdy3) s3_valid_q  <= s2_valid_q;
      if (rdy4) out_valid_q <= s3_valid_q;
    end
  end

  // stage 1: effective clip and source rectangle
  box_t surf, req, clip_d, area, part, src_d;
  box_t s1_clip_q, s1_src_q;
  logic signed [CoordW-1:0] s1_tx_q, s1_ty_q;

  always_comb begin
    surf = '{x: '0, y: '0, w: surface_width_q, h: surface_height_q};
    req  = '{x: clip_left_q, y: clip_top_q, w: clip_width_q, h: clip_height_q};
    if (clip_width_q == '0 || clip_height_q == '0) clip_d = surf;
    else clip_d = box_and(req, surf);
    area = '{x: in_word_i.area_x, y: in_word_i.area_y,
             w: in_word_i.area_w, h: in_word_i.area_h};
    part = '{x: in_word_i.part_x, y: in_word_i.part_y,
             w: in_word_i.part_w, h: in_word_i.part_h};
    if (in_word_i.part_given) src_d = box_and(part, area);
    else src_d = area;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_clip_q <= clip_d;
      s1_src_q  <= src_d;
      s1_tx_q   <= in_word_i.target_x;
      s1_ty_q   <= in_word_i.target_y;
    end
  end

  // stage 2: destination placed at the target, cut to the clip
  box_t place_d, dst_d, s2_src_q, s2_dst_q;
  logic signed [CoordW-1:0] s2_tx_q, s2_ty_q;

  assign place_d = '{x: s1_tx_q, y: s1_ty_q, w: s1_src_q.w, h: s1_src_q.h};
  assign dst_d   = box_and(place_d, s1_clip_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_q) begin
      s2_src_q <= s1_src_q;
      s2_dst_q <= dst_d;
      s2_tx_q  <= s1_tx_q;
      s2_ty_q  <= s1_ty_q;
    end
  end

  // stage 3: move the source by what was cut off the left and top
  box_t from_d, to_d, s3_from_q, s3_to_q;
  logic signed [CoordW:0]  dx, dy;
  logic signed [EdgeW-1:0] sx, sy;

  always_comb begin
    from_d = s2_src_q;
    to_d   = s2_dst_q;
    dx = (CoordW+1)'(s2_dst_q.x) - (CoordW+1)'(s2_tx_q);
    dy = (CoordW+1)'(s2_dst_q.y) - (CoordW+1)'(s2_ty_q);
    sx = EdgeW'(s2_src_q.x) + EdgeW'(dx);
    sy = EdgeW'(s2_src_q.y) + EdgeW'(dy);
    if (dx > 17'sd0) begin
      if (dx < $signed({2'b00, s2_src_q.w})) begin
        from_d.w = s2_src_q.w - dx[SizeW-1:0];
        from_d.x = (sx > CoordMax) ? CoordMax[CoordW-1:0] : sx[CoordW-1:0];
      end else begin
        to_d.w = '0;
      end
    end
    if (dy > 17'sd0) begin
      if (dy < $signed({2'b00, s2_src_q.h})) begin
        from_d.h = s2_src_q.h - dy[SizeW-1:0];
        from_d.y = (sy > CoordMax) ? CoordMax[CoordW-1:0] : sy[CoordW-1:0];
      end else begin
        to_d.h = '0;
      end
    end
    // nothing to copy: every field reads zero
    if (s2_src_q.w == '0 || s2_src_q.h == '0) begin
      from_d = '0;
      to_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_valid_q) begin
      s3_from_q <= from_d;
      s3_to_q   <= to_d;
    end
  end

  // stage 4: pixel count into the output register
  out_word_t out_word_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_valid_q) begin
      out_word_q.from_x      <= s3_from_q.x;
      out_word_q.from_y      <= s3_from_q.y;
      out_word_q.from_w      <= s3_from_q.w;
      out_word_q.from_h      <= s3_from_q.h;
      out_word_q.to_x        <= s3_to_q.x;
      out_word_q.to_y        <= s3_to_q.y;
      out_word_q.to_w        <= s3_to_q.w;
      out_word_q.to_h        <= s3_to_q.h;
      out_word_q.pixel_total <= PixW'(s3_to_q.w) * PixW'(s3_to_q.h);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted word did not enter stage one");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q)
    else $error("input stalled with an empty stage");

  a_src_covers_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.from_w >= out_word_o.to_w &&
                    out_word_o.from_h >= out_word_o.to_h)
    else $error("destination wider than shifted source");

endmodule
